FILE: hdl/odo_pkg.sv
// Shared types, constants and saturation helpers for the wheel odometry block.
package odo_pkg;

    // Number of CORDIC rotations per angle (valid range 12 to 32).
    localparam int CORDIC_STEPS = 24;
    localparam int STEP_W       = 5;

    // Angles are in 2^-28 rad.
    localparam logic signed [33:0] PI_Q      = 34'sd843314857;
    localparam logic signed [33:0] TWO_PI_Q  = 34'sd1686629713;
    localparam logic signed [33:0] WRAP_HI_Q = 34'sd843314855;
    localparam logic signed [31:0] PI_Q32    = 32'sd843314857;
    localparam logic signed [31:0] HALF_PI_Q = 32'sd421657428;
    localparam logic signed [32:0] CORDIC_GAIN_Q = 33'sd652032874;

    // Arctangent of 2^-i in 2^-28 rad.
    localparam logic [27:0] ATAN_TAB [32] = '{
        28'd210828714, 28'd124459457, 28'd65760959, 28'd33381290, 28'd16755422,
        28'd8385879, 28'd4193963, 28'd2097109, 28'd1048571, 28'd524287,
        28'd262144, 28'd131072, 28'd65536, 28'd32768, 28'd16384, 28'd8192,
        28'd4096, 28'd2048, 28'd1024, 28'd512, 28'd256, 28'd128, 28'd64,
        28'd32, 28'd16, 28'd8, 28'd4, 28'd2, 28'd1, 28'd0, 28'd0, 28'd0
    };

    localparam logic signed [31:0] TICK_LIMIT = 32'sd65535;

    // Configuration register indexes.
    localparam logic [1:0] REG_SLOTS = 2'd0;
    localparam logic [1:0] REG_CIRC  = 2'd1;
    localparam logic [1:0] REG_BASE  = 2'd2;

    // Shared divider sizing.
    localparam int DIV_NUM_W = 42;
    localparam int DIV_DEN_W = 24;
    localparam int DIV_CNT_W = 6;
    localparam logic [DIV_CNT_W-1:0] WHEEL_DIV_STEPS = 6'd42;
    localparam logic [DIV_CNT_W-1:0] RATIO_DIV_STEPS = 6'd33;

    typedef struct packed {
        logic                 load;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] rem;
        logic [DIV_DEN_W-1:0] den;
        logic [DIV_CNT_W-1:0] steps;
    } odo_div_req_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_MUL_L, ST_LOAD_L, ST_DIV_L, ST_FIN_L,
        ST_MUL_R, ST_LOAD_R, ST_DIV_R, ST_FIN_R,
        ST_SUMDIFF, ST_LOAD_H, ST_DIV_H, ST_FIN_H,
        ST_ANG, ST_WRAP_A, ST_CORD_INIT, ST_CORD, ST_CORD_FIN,
        ST_MX_LO, ST_MX_HI, ST_MX_FIN, ST_MY_LO, ST_MY_HI, ST_MY_FIN,
        ST_POSE, ST_WRAP_H, ST_OUT
    } odo_state_t;

    // Signed 40-bit result from sign and magnitude, saturated.
    function automatic logic signed [39:0] sat40(input logic neg, input logic [42:0] mag);
        logic [43:0] neg_mag;
        neg_mag = 44'd0 - {1'b0, mag};
        if (neg) begin
            if (mag > 43'd549755813888) return 40'sh80_0000_0000;
            return neg_mag[39:0];
        end
        if (mag > 43'd549755813887) return 40'sh7F_FFFF_FFFF;
        return mag[39:0];
    endfunction

    // Signed 32-bit result from sign and magnitude, saturated or forced to a limit.
    function automatic logic signed [31:0] sat32(input logic neg, input logic force_sat,
                                                 input logic [33:0] mag);
        logic [34:0] neg_mag;
        neg_mag = 35'd0 - {1'b0, mag};
        if (neg) begin
            if (force_sat || mag > 34'd2147483648) return 32'sh8000_0000;
            return neg_mag[31:0];
        end
        if (force_sat || mag > 34'd2147483647) return 32'sh7FFF_FFFF;
        return mag[31:0];
    endfunction

    // Saturating 48-bit accumulate.
    function automatic logic signed [47:0] sat48_add(input logic signed [47:0] acc,
                                                     input logic signed [39:0] inc);
        logic signed [48:0] s;
        s = 49'(acc) + 49'(inc);
        if (s > 49'sh0_7FFF_FFFF_FFFF) return 48'sh7FFF_FFFF_FFFF;
        if (s < -49'sh0_8000_0000_0000) return 48'sh8000_0000_0000;
        return s[47:0];
    endfunction

endpackage

FILE: hdl/odo_div.sv
// Bit-serial restoring divider shared by the wheel distance and heading ratios.
module odo_div (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  odo_pkg::odo_div_req_t            req,
    output logic                             done,
    output logic [odo_pkg::DIV_NUM_W-1:0]    quot
);
    import odo_pkg::*;

    logic [DIV_NUM_W-1:0] num_reg, num_next;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_DEN_W:0]   rem_sh;
    logic [DIV_DEN_W:0]   rem_sub;
    logic                 ge;

    // One quotient bit per cycle; quotient bits shift in at the bottom of the numerator.
    always_comb begin
        rem_sh   = {rem_reg, num_reg[DIV_NUM_W-1]};
        rem_sub  = rem_sh - {1'b0, den_reg};
        ge       = (rem_sh >= {1'b0, den_reg});
        rem_next = ge ? rem_sub[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
        num_next = {num_reg[DIV_NUM_W-2:0], ge};
    end

    // Control: busy flag, step count and completion pulse.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.load) begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.steps;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Operands and partial remainder.
    always_ff @(posedge aclk) begin
        if (req.load) begin
            num_reg <= req.num;
            rem_reg <= req.rem;
            den_reg <= req.den;
        end else if (busy_reg) begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign quot = num_reg;

endmodule

FILE: hdl/differential_drive_odometry_top.sv
// Differential-drive wheel odometry: tick counts in, wheel distances and pose out.
//
//  Channel  Direction  Handshake          Contents
//  s_       in         s_tvalid/s_tready  left_ticks, right_ticks
//  m_       out        m_tvalid/m_tready  distances, displacement, heading, pose
//  cfg_     in         cfg_wr_en          encoder_slots, wheel_circumference, wheel_base
//
//  The time a word occupies the sequencer is set by the bit-serial divider (one run per
//  wheel and one for the heading ratio) and the CORDIC rotation loop of CORDIC_STEPS
//  iterations; each of the two angle wraps may repeat its wrap step.
//  s_tready is high only while the sequencer is idle.
//  aresetn is synchronous, clears the pose and the previous counts, and sets the registers to their defaults.
//  A result held on m_ stalls only the final step of the next word.
module differential_drive_odometry_top (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [63:0]   s_tdata,   // left_ticks[31:0], right_ticks[63:32]
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [319:0]  m_tdata,   // left_distance[39:0], right_distance[79:40],
                                     // delta_x[119:80], delta_y[159:120],
                                     // delta_heading[191:160], pose_x[239:192],
                                     // pose_y[287:240], pose_heading[318:288]
    input  logic          cfg_wr_en,
    input  logic [1:0]    cfg_index,
    input  logic [23:0]   cfg_wdata
);
    import odo_pkg::*;

    odo_state_t state_reg, state_next;

    logic [12:0] slots_reg;
    logic [23:0] circ_reg;
    logic [23:0] base_reg;
    logic [12:0] slots_nz;
    logic [23:0] base_nz;

    logic [31:0]        prev_l_reg, prev_r_reg;
    logic signed [47:0] pose_x_reg, pose_y_reg;
    logic signed [30:0] heading_reg;

    logic [15:0] mag_l_reg, mag_r_reg;
    logic        neg_l_reg, neg_r_reg;
    logic [63:0] prod_reg;
    logic [40:0] hi_reg;
    logic signed [39:0] dl_reg, dr_reg;
    logic signed [40:0] sum_reg, diff_reg;
    logic [40:0] sum_mag_reg;
    logic        sum_neg_reg, diff_neg_reg, sat_d_reg, sat_h_reg;
    logic signed [31:0] dth_reg, half_reg;
    logic signed [33:0] ang_reg;
    logic signed [32:0] x_reg, y_reg;
    logic signed [31:0] z_reg;
    logic        flip_reg;
    logic [STEP_W-1:0] iter_reg;
    logic [31:0] cos_mag_reg, sin_mag_reg;
    logic        cos_neg_reg, sin_neg_reg;
    logic signed [39:0] dx_reg, dy_reg;
    logic [319:0] out_data_reg;
    logic        m_valid_reg;

    logic [16:0] tick_l, tick_r;
    odo_div_req_t div_req;
    logic        div_done;
    logic [DIV_NUM_W-1:0] div_quot;
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic [33:0] lo_rnd;
    logic [42:0] mul_mag;
    logic        mul_neg;
    logic [40:0] diff_abs;
    logic [33:0] dth_sum, dth_mag;
    logic [32:0] half_sum;
    logic [33:0] half_mag;
    logic        ang_hi, ang_lo;
    logic signed [33:0] ang_wrapped;
    logic signed [32:0] x_sh, y_sh;
    logic signed [31:0] atan_k;
    logic        out_fire;

    // Tick difference modulo 2^32, saturated to the tick limit, as sign and magnitude.
    function automatic logic [16:0] tick_sat(input logic [31:0] cur, input logic [31:0] prev);
        logic signed [31:0] d;
        logic [31:0]        nd;
        d  = signed'(cur - prev);
        nd = 32'd0 - cur + prev;
        if (d > TICK_LIMIT) return {1'b0, 16'hFFFF};
        if (d < -TICK_LIMIT) return {1'b1, 16'hFFFF};
        if (d < 0) return {1'b1, nd[15:0]};
        return {1'b0, d[15:0]};
    endfunction

    odo_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .done    (div_done),
        .quot    (div_quot)
    );

    // A register value of zero acts as one.
    assign slots_nz = (slots_reg == '0) ? 13'd1 : slots_reg;
    assign base_nz  = (base_reg == '0) ? 24'd1 : base_reg;

    assign tick_l = tick_sat(s_tdata[31:0], prev_l_reg);
    assign tick_r = tick_sat(s_tdata[63:32], prev_r_reg);

    // Shared 32x32 multiplier.
    assign mul_p = mul_a * mul_b;

    // Arithmetic helpers driven from registered operands.
    always_comb begin
        diff_abs = diff_reg[40] ? 41'(-diff_reg) : diff_reg;
        lo_rnd   = 34'((prod_reg + 64'h4000_0000) >> 31);
        mul_mag  = {1'b0, hi_reg, 1'b0} + {9'b0, lo_rnd};
        mul_neg  = sum_neg_reg ^ ((state_reg == ST_MX_FIN) ? cos_neg_reg : sin_neg_reg);
        dth_sum  = {1'b0, div_quot[32:0]} + 34'd1;
        dth_mag  = {1'b0, dth_sum[33:1]};
        half_sum = {1'b0, div_quot[32:1]} + 33'd1;
        half_mag = {2'b0, half_sum[32:1]};
        ang_hi   = (ang_reg > WRAP_HI_Q);
        ang_lo   = (ang_reg < -PI_Q);
        ang_wrapped = ang_hi ? (ang_reg - TWO_PI_Q) : (ang_reg + TWO_PI_Q);
        x_sh     = x_reg >>> iter_reg;
        y_sh     = y_reg >>> iter_reg;
        atan_k   = {4'b0, ATAN_TAB[iter_reg]};
        out_fire = !m_valid_reg || m_tready;
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (s_tvalid) state_next = ST_MUL_L;
            ST_MUL_L:     state_next = ST_LOAD_L;
            ST_LOAD_L:    state_next = ST_DIV_L;
            ST_DIV_L:     if (div_done) state_next = ST_FIN_L;
            ST_FIN_L:     state_next = ST_MUL_R;
            ST_MUL_R:     state_next = ST_LOAD_R;
            ST_LOAD_R:    state_next = ST_DIV_R;
            ST_DIV_R:     if (div_done) state_next = ST_FIN_R;
            ST_FIN_R:     state_next = ST_SUMDIFF;
            ST_SUMDIFF:   state_next = ST_LOAD_H;
            ST_LOAD_H:    state_next = ST_DIV_H;
            ST_DIV_H:     if (div_done) state_next = ST_FIN_H;
            ST_FIN_H:     state_next = ST_ANG;
            ST_ANG:       state_next = ST_WRAP_A;
            ST_WRAP_A:    if (!ang_hi && !ang_lo) state_next = ST_CORD_INIT;
            ST_CORD_INIT: state_next = ST_CORD;
            ST_CORD:      if (iter_reg == STEP_W'(CORDIC_STEPS - 1)) state_next = ST_CORD_FIN;
            ST_CORD_FIN:  state_next = ST_MX_LO;
            ST_MX_LO:     state_next = ST_MX_HI;
            ST_MX_HI:     state_next = ST_MX_FIN;
            ST_MX_FIN:    state_next = ST_MY_LO;
            ST_MY_LO:     state_next = ST_MY_HI;
            ST_MY_HI:     state_next = ST_MY_FIN;
            ST_MY_FIN:    state_next = ST_POSE;
            ST_POSE:      state_next = ST_WRAP_H;
            ST_WRAP_H:    if (!ang_hi && !ang_lo) state_next = ST_OUT;
            ST_OUT:       if (out_fire) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Control outputs: handshake, divider requests and multiplier operands.
    always_comb begin
        s_tready      = (state_reg == ST_IDLE);
        div_req       = '0;
        mul_a         = '0;
        mul_b         = '0;
        unique case (state_reg)
            ST_MUL_L: begin
                mul_a = {16'b0, mag_l_reg};
                mul_b = {8'b0, circ_reg};
            end
            ST_MUL_R: begin
                mul_a = {16'b0, mag_r_reg};
                mul_b = {8'b0, circ_reg};
            end
            ST_LOAD_L, ST_LOAD_R: begin
                div_req.load  = 1'b1;
                div_req.num   = {1'b0, prod_reg[39:0], 1'b0} + {29'b0, slots_nz};
                div_req.rem   = '0;
                div_req.den   = {10'b0, slots_nz, 1'b0};
                div_req.steps = WHEEL_DIV_STEPS;
            end
            ST_LOAD_H: begin
                div_req.load  = 1'b1;
                div_req.num   = {diff_abs[3:0], 38'b0};
                div_req.rem   = diff_abs[27:4];
                div_req.den   = base_nz;
                div_req.steps = RATIO_DIV_STEPS;
            end
            ST_MX_LO: begin
                mul_a = sum_mag_reg[31:0];
                mul_b = cos_mag_reg;
            end
            ST_MX_HI: begin
                mul_a = {23'b0, sum_mag_reg[40:32]};
                mul_b = cos_mag_reg;
            end
            ST_MY_LO: begin
                mul_a = sum_mag_reg[31:0];
                mul_b = sin_mag_reg;
            end
            ST_MY_HI: begin
                mul_a = {23'b0, sum_mag_reg[40:32]};
                mul_b = sin_mag_reg;
            end
            default: begin
            end
        endcase
    end

    // Control state: sequencer, output valid, configuration and odometry state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            slots_reg   <= 13'd20;
            circ_reg    <= 24'd52224;
            base_reg    <= 24'd38400;
            prev_l_reg  <= '0;
            prev_r_reg  <= '0;
            pose_x_reg  <= '0;
            pose_y_reg  <= '0;
            heading_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_SLOTS: slots_reg <= cfg_wdata[12:0];
                    REG_CIRC:  circ_reg  <= cfg_wdata;
                    REG_BASE:  base_reg  <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (s_tvalid && s_tready) begin
                prev_l_reg <= s_tdata[31:0];
                prev_r_reg <= s_tdata[63:32];
            end
            if (state_reg == ST_POSE) begin
                pose_x_reg <= sat48_add(pose_x_reg, dx_reg);
                pose_y_reg <= sat48_add(pose_y_reg, dy_reg);
            end
            if (state_reg == ST_OUT && out_fire) begin
                heading_reg <= ang_reg[30:0];
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers, one step per sequencer state.
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                {neg_l_reg, mag_l_reg} <= tick_l;
                {neg_r_reg, mag_r_reg} <= tick_r;
            end
            ST_MUL_L, ST_MUL_R, ST_MX_LO, ST_MY_LO: prod_reg <= mul_p;
            ST_MX_HI, ST_MY_HI:   hi_reg <= mul_p[40:0];
            ST_FIN_L:   dl_reg <= sat40(neg_l_reg, {1'b0, div_quot});
            ST_FIN_R:   dr_reg <= sat40(neg_r_reg, {1'b0, div_quot});
            ST_SUMDIFF: begin
                sum_reg  <= 41'(dl_reg) + 41'(dr_reg);
                diff_reg <= 41'(dr_reg) - 41'(dl_reg);
            end
            ST_LOAD_H: begin
                diff_neg_reg <= diff_reg[40];
                sat_d_reg    <= (diff_abs >= {14'b0, base_nz, 3'b0});
                sat_h_reg    <= (diff_abs >= {13'b0, base_nz, 4'b0});
                sum_neg_reg  <= sum_reg[40];
                sum_mag_reg  <= sum_reg[40] ? 41'(-sum_reg) : sum_reg;
            end
            ST_FIN_H: begin
                dth_reg  <= sat32(diff_neg_reg, sat_d_reg, dth_mag);
                half_reg <= sat32(diff_neg_reg, sat_h_reg, half_mag);
            end
            ST_ANG:  ang_reg <= 34'(heading_reg) + 34'(half_reg);
            ST_WRAP_A, ST_WRAP_H: if (ang_hi || ang_lo) ang_reg <= ang_wrapped;
            ST_CORD_INIT: begin
                x_reg    <= CORDIC_GAIN_Q;
                y_reg    <= '0;
                iter_reg <= '0;
                // Angles beyond a quarter turn rotate by half a turn and negate at the end.
                if (signed'(ang_reg[31:0]) > HALF_PI_Q) begin
                    z_reg    <= ang_reg[31:0] - PI_Q32;
                    flip_reg <= 1'b1;
                end else if (signed'(ang_reg[31:0]) < -HALF_PI_Q) begin
                    z_reg    <= ang_reg[31:0] + PI_Q32;
                    flip_reg <= 1'b1;
                end else begin
                    z_reg    <= ang_reg[31:0];
                    flip_reg <= 1'b0;
                end
            end
            ST_CORD: begin
                iter_reg <= iter_reg + 1'b1;
                if (!z_reg[31]) begin
                    x_reg <= x_reg - y_sh;
                    y_reg <= y_reg + x_sh;
                    z_reg <= z_reg - atan_k;
                end else begin
                    x_reg <= x_reg + y_sh;
                    y_reg <= y_reg - x_sh;
                    z_reg <= z_reg + atan_k;
                end
            end
            ST_CORD_FIN: begin
                cos_mag_reg <= x_reg[32] ? 32'(-x_reg) : x_reg[31:0];
                sin_mag_reg <= y_reg[32] ? 32'(-y_reg) : y_reg[31:0];
                cos_neg_reg <= flip_reg ? (x_reg > 0) : x_reg[32];
                sin_neg_reg <= flip_reg ? (y_reg > 0) : y_reg[32];
            end
            ST_MX_FIN: dx_reg <= sat40(mul_neg, mul_mag);
            ST_MY_FIN: dy_reg <= sat40(mul_neg, mul_mag);
            ST_POSE:   ang_reg <= 34'(heading_reg) + 34'(dth_reg);
            ST_OUT: begin
                if (out_fire) begin
                    out_data_reg <= {1'b0, ang_reg[30:0], pose_y_reg, pose_x_reg, dth_reg,
                                     dy_reg, dx_reg, dr_reg, dl_reg};
                end
            end
            default: begin
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

FILE: hdl/odo_checker.sv
// Port-level checks for the odometry top level, attached by bind.
module odo_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [319:0] m_tdata
);

    // A held result word stays valid.
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped while stalled");

    // A held result word does not change.
    a_m_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result word changed while stalled");

    // The block is busy right after it takes a word.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken again in the cycle after a word");

    // Reset leaves no result pending.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind differential_drive_odometry_top odo_checker u_odo_checker (.*);

FILE: tb/tb_differential_drive_odometry_top.sv
// Self-checking testbench for the differential-drive odometry block: stream stimulus, pose predictor.
`timescale 1ns / 1ps

module tb_differential_drive_odometry_top;
    import odo_pkg::*;

    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 250;
    localparam int CYCLE_LIMIT   = 1000000;

    typedef enum logic [1:0] {OP_WORD, OP_CFG, OP_DRAIN} odo_op_t;

    typedef struct {
        odo_op_t     op;
        logic [31:0] left;
        logic [31:0] right;
        logic [1:0]  idx;
        logic [23:0] val;
    } odo_item_t;

    typedef struct {
        logic signed [39:0] dl, dr, dx, dy;
        logic signed [31:0] dth;
        logic signed [47:0] px, py;
        logic signed [30:0] hd;
    } odo_result_t;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [63:0]   s_tdata = '0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [319:0]  m_tdata;
    logic          cfg_wr_en = 1'b0;
    logic [1:0]    cfg_index = '0;
    logic [23:0]   cfg_wdata = '0;

    differential_drive_odometry_top uut (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Predictor copy of the registers and the pose state.
    logic [12:0] slots_reg = 13'd20;
    logic [23:0] circ_reg  = 24'd52224;
    logic [23:0] base_reg  = 24'd38400;
    logic [31:0] last_left = '0, last_right = '0;
    longint      pose_x_q = 0, pose_y_q = 0, heading_q = 0;

    odo_item_t   pending_words[$];
    odo_result_t expected_poses[$];
    int          failures = 0;

    function automatic longint clamp(longint v, int w);
        longint lim;
        lim = longint'(1) <<< (w - 1);
        if (v > lim - 1) return lim - 1;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic longint wrap_ang(longint v);
        longint r;
        r = (v + longint'(PI_Q)) % longint'(TWO_PI_Q);
        if (r < 0) r += longint'(TWO_PI_Q);
        return r - longint'(PI_Q);
    endfunction

    function automatic longint tick_step(logic [31:0] cur, logic [31:0] prev);
        logic [31:0] d;
        d = cur - prev;
        return clamp(longint'($signed(d)), 17) > 65535 ? 65535 :
               (longint'($signed(d)) > 65535 ? 65535 :
               (longint'($signed(d)) < -65535 ? -65535 : longint'($signed(d))));
    endfunction

    function automatic longint wheel_len(longint d);
        longint unsigned sl, m, q;
        sl = (slots_reg == 0) ? 1 : longint'(slots_reg);
        m = longint'(d < 0 ? -d : d) * longint'(circ_reg);
        q = (2 * m + sl) / (2 * sl);
        return clamp(d < 0 ? -longint'(q) : longint'(q), 40);
    endfunction

    // round(n * 2^sh / b), saturated to 32 bits.
    function automatic longint angle_ratio(longint n, int sh, longint unsigned b);
        longint unsigned a, q;
        a = longint'(n < 0 ? -n : n);
        if (a >= (b << (31 - sh))) return n < 0 ? -(longint'(1) <<< 31) : (longint'(1) <<< 31) - 1;
        q = ((a << (sh + 1)) + b) / (2 * b);
        return clamp(n < 0 ? -longint'(q) : longint'(q), 32);
    endfunction

    // round(a * c / 2^31), ties away from zero.
    function automatic longint round_mul(longint a, longint c);
        longint unsigned ua, uc, r;
        ua = longint'(a < 0 ? -a : a);
        uc = longint'(c < 0 ? -c : c);
        r = (ua >> 32) * uc * 2 + (((ua & 64'hFFFF_FFFF) * uc + (64'd1 << 30)) >> 31);
        return ((a < 0) != (c < 0)) ? -longint'(r) : longint'(r);
    endfunction

    task automatic rotate(input longint phi, output longint c, output longint s);
        longint x, y, z, nx, t;
        bit flip;
        x = longint'(CORDIC_GAIN_Q);
        y = 0;
        z = phi;
        flip = 0;
        if (z > longint'(HALF_PI_Q)) begin
            z -= longint'(PI_Q);
            flip = 1;
        end else if (z < -longint'(HALF_PI_Q)) begin
            z += longint'(PI_Q);
            flip = 1;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            t = longint'(ATAN_TAB[i & 31]);
            if (z >= 0) begin
                nx = x - (y >>> (i & 31));
                y = y + (x >>> (i & 31));
                z -= t;
            end else begin
                nx = x + (y >>> (i & 31));
                y = y - (x >>> (i & 31));
                z += t;
            end
            x = nx;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    // Advance the predicted pose by one word and queue the expected result.
    task automatic advance_pose(input logic [31:0] l, input logic [31:0] r);
        longint unsigned b;
        longint dl, dr, sum, diff, dth, half, c, s, dx, dy;
        odo_result_t e;
        b = (base_reg == 0) ? 1 : longint'(base_reg);
        dl = wheel_len(tick_step(l, last_left));
        dr = wheel_len(tick_step(r, last_right));
        sum = dl + dr;
        diff = dr - dl;
        dth = angle_ratio(diff, 28, b);
        half = angle_ratio(diff, 27, b);
        last_left = l;
        last_right = r;
        rotate(wrap_ang(heading_q + half), c, s);
        dx = clamp(round_mul(sum, c), 40);
        dy = clamp(round_mul(sum, s), 40);
        pose_x_q = clamp(pose_x_q + dx, 48);
        pose_y_q = clamp(pose_y_q + dy, 48);
        heading_q = wrap_ang(heading_q + dth);
        e.dl = dl[39:0];
        e.dr = dr[39:0];
        e.dx = dx[39:0];
        e.dy = dy[39:0];
        e.dth = dth[31:0];
        e.px = pose_x_q[47:0];
        e.py = pose_y_q[47:0];
        e.hd = heading_q[30:0];
        expected_poses.push_back(e);
    endtask

    // Driver: feeds words, register writes and drain pauses from the pending queue.
    int gap_cnt = 0;
    int hold_cnt = 0;
    always @(posedge aclk) begin : driver
        bit nxt_valid;
        bit nxt_wr;
        nxt_valid = s_tvalid;
        nxt_wr = 1'b0;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                advance_pose(s_tdata[31:0], s_tdata[63:32]);
                nxt_valid = 1'b0;
                gap_cnt = $urandom_range(0, 4);
            end else if (!s_tvalid) begin
                if (gap_cnt > 0) begin
                    gap_cnt--;
                end else if (pending_words.size() > 0) begin
                    case (pending_words[0].op)
                        OP_WORD: begin
                            s_tdata <= {pending_words[0].right, pending_words[0].left};
                            nxt_valid = 1'b1;
                            void'(pending_words.pop_front());
                        end
                        OP_DRAIN: begin
                            if (expected_poses.size() == 0) begin
                                if (hold_cnt < SETTLE_CYCLES) begin
                                    hold_cnt++;
                                end else begin
                                    hold_cnt = 0;
                                    void'(pending_words.pop_front());
                                end
                            end
                        end
                        default: begin
                            case (pending_words[0].idx)
                                REG_SLOTS: slots_reg = pending_words[0].val[12:0];
                                REG_CIRC:  circ_reg = pending_words[0].val;
                                REG_BASE:  base_reg = pending_words[0].val;
                                default: ;
                            endcase
                            cfg_index <= pending_words[0].idx;
                            cfg_wdata <= pending_words[0].val;
                            nxt_wr = 1'b1;
                            void'(pending_words.pop_front());
                        end
                    endcase
                end
            end
        end
        s_tvalid <= nxt_valid;
        cfg_wr_en <= nxt_wr;
    end

    function automatic void check_field(string name, longint e, longint a);
        if (e != a) begin
            $error("%s mismatch: expected %0d, actual %0d", name, e, a);
            failures++;
        end
    endfunction

    // Monitor: random back-pressure and field-by-field comparison.
    int stall_cnt = 0;
    always @(posedge aclk) begin : monitor
        bit nxt_ready;
        odo_result_t e;
        nxt_ready = m_tready;
        if (!aresetn) begin
            nxt_ready = 1'b1;
        end else if (m_tvalid && m_tready) begin
            if (expected_poses.size() == 0) begin
                $error("result word with no expectation waiting");
                failures++;
            end else begin
                e = expected_poses.pop_front();
                check_field("left_distance", e.dl, $signed(m_tdata[39:0]));
                check_field("right_distance", e.dr, $signed(m_tdata[79:40]));
                check_field("delta_x", e.dx, $signed(m_tdata[119:80]));
                check_field("delta_y", e.dy, $signed(m_tdata[159:120]));
                check_field("delta_heading", e.dth, $signed(m_tdata[191:160]));
                check_field("pose_x", e.px, $signed(m_tdata[239:192]));
                check_field("pose_y", e.py, $signed(m_tdata[287:240]));
                check_field("pose_heading", e.hd, $signed(m_tdata[318:288]));
            end
            stall_cnt = $urandom_range(0, 4);
            nxt_ready = (stall_cnt == 0);
        end else if (!m_tready) begin
            if (stall_cnt > 1) stall_cnt--;
            else nxt_ready = 1'b1;
        end
        m_tready <= nxt_ready;
    end

    // Cycle limit.
    int cycle_cnt = 0;
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic add_word(logic [31:0] l, logic [31:0] r);
        odo_item_t it;
        it.op = OP_WORD;
        it.left = l;
        it.right = r;
        it.idx = '0;
        it.val = '0;
        pending_words.push_back(it);
    endtask

    task automatic add_cfg(logic [1:0] idx, logic [23:0] val);
        odo_item_t it;
        it.op = OP_DRAIN;
        it.left = '0;
        it.right = '0;
        it.idx = idx;
        it.val = val;
        pending_words.push_back(it);
        it.op = OP_CFG;
        pending_words.push_back(it);
    endtask

    function automatic logic [23:0] pick_len();
        case ($urandom_range(0, 5))
            0: return 24'd0;
            1: return 24'd1;
            2: return 24'hFFFFFF;
            3: return 24'($urandom_range(1, 255));
            4: return 24'($urandom_range(10000, 100000));
            default: return 24'($urandom);
        endcase
    endfunction

    initial begin : stimulus
        logic [31:0] l, r;
        int n_items;
        l = 0;
        r = 0;

        // Directed words at reset settings: straight, turns, reverse, jumps, wrap.
        add_word(32'd0, 32'd0);
        add_word(32'd10, 32'd10);
        add_word(32'd10, 32'd25);
        add_word(32'd30, 32'd25);
        add_word(32'd20, 32'd15);
        add_word(32'h7FFF_FFFF, 32'h8000_0000);
        add_word(32'h8000_0000, 32'h7FFF_FFFF);
        add_word(32'hFFFF_FFFF, 32'h0000_0000);
        add_word(32'h0000_0005, 32'hFFFF_FFF0);
        add_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);

        // Zero slots and base act as one; large wheel differences saturate the heading.
        add_cfg(REG_SLOTS, 24'd0);
        add_cfg(REG_BASE, 24'd0);
        add_cfg(REG_CIRC, 24'hFFFFFF);
        add_word(32'd100, 32'd65635);
        add_word(32'd0, 32'd0);
        // Slots above 4096, unused register index ignored.
        add_cfg(REG_SLOTS, 24'hFFFFFF);
        add_cfg(REG_UNUSED, 24'd7);
        add_cfg(REG_BASE, 24'hFFFFFF);
        add_word(32'd9000, 32'd4000);
        add_word(32'hFFF0_0000, 32'h0010_0000);
        l = 32'hFFF0_0000;
        r = 32'h0010_0000;

        // Long straight run at maximum distance per word to saturate the pose.
        add_cfg(REG_SLOTS, 24'd1);
        add_cfg(REG_BASE, 24'd1);
        for (int i = 0; i < 300; i++) begin
            l += 32'd65535;
            r += 32'd65535;
            add_word(l, r);
        end

        // Random phases with fresh register settings.
        for (int ph = 0; ph < 8; ph++) begin
            case ($urandom_range(0, 4))
                0: add_cfg(REG_SLOTS, 24'd1);
                1: add_cfg(REG_SLOTS, 24'd4096);
                2: add_cfg(REG_SLOTS, 24'd8191);
                3: add_cfg(REG_SLOTS, 24'd20);
                default: add_cfg(REG_SLOTS, 24'($urandom));
            endcase
            add_cfg(REG_CIRC, pick_len());
            add_cfg(REG_BASE, pick_len());
            n_items = 120;
            for (int i = 0; i < n_items; i++) begin
                case ($urandom_range(0, 9))
                    0: begin
                        l = $urandom;
                        r = $urandom;
                    end
                    1: begin
                        l += 32'($urandom_range(0, 140000)) - 32'd70000;
                        r += 32'($urandom_range(0, 140000)) - 32'd70000;
                    end
                    default: begin
                        l += 32'($urandom_range(0, 400)) - 32'd200;
                        r += 32'($urandom_range(0, 400)) - 32'd200;
                    end
                endcase
                add_word(l, r);
            end
        end

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_words.size() > 0 || expected_poses.size() > 0 || s_tvalid)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (failures == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

FILE: files.f
hdl/odo_pkg.sv
hdl/odo_div.sv
hdl/differential_drive_odometry_top.sv
hdl/odo_checker.sv
tb/tb_differential_drive_odometry_top.sv
